### rtl/tcsn_pkg.sv
// Shared constants, types and helper functions for the tryte chunk sum normalizer.
// No dependencies; every other file of the block imports this package.
package tcsn_pkg;

   localparam int TRYTE_W       = 5;
   localparam int CHUNK_LEN_DEF = 27;
   localparam int TRYTE_MAX_DEF = 13;

   // chunk buffer banks, and depth of the small descriptor and result queues
   localparam int NUM_BANKS  = 2;
   localparam int FIFO_DEPTH = 2;

   typedef enum logic [0:0] {
      BACK_IDLE,
      BACK_RUN
   } back_state_type;

   // width of a signed sum of chunk_len trytes, never narrower than a tryte plus sign
   function automatic int sum_width(input int chunk_len, input int tryte_max);
      int raw;
      raw = $clog2(chunk_len * tryte_max + 1) + 1;
      return (raw > TRYTE_W + 1) ? raw : TRYTE_W + 1;
   endfunction

   // index width for a counter over chunk_len positions
   function automatic int index_width(input int chunk_len);
      return (chunk_len > 1) ? $clog2(chunk_len) : 1;
   endfunction

endpackage

### rtl/tryte_chunk_sum_normalizer.sv
// Top level of the tryte chunk sum normalizer.
// Depends on tcsn_pkg, tcsn_front, tcsn_fifo, tcsn_ram and tcsn_back.
//
// Usage:
//   Input queue: drive req_tryte_in with push; a tryte is taken at a clock edge
//   with push high and full low. Out-of-range codes saturate to +/-TRYTE_MAX.
//   Every CHUNK_LEN trytes form a chunk; when the chunk is complete its sum is
//   balanced to zero (earliest trytes absorb it first) and the chunk comes out.
//   Result queue: while empty is low, rsp_tryte_out/rsp_chunk_last show the
//   oldest result; it is taken at an edge with pop high. rsp_chunk_last marks
//   the final tryte of each chunk.
//   Path: the first result of a chunk passes the descriptor queue, the back's
//   sum load, the buffer read and the result queue; the rest follow one per
//   cycle while pop stays high. Throughput: one tryte per cycle on input while
//   full is low. Per chunk the back loads the chunk sum, reads each tryte once
//   and drains the last read before the next load, setting the sustained rate.
//   Stall: when pop stays low the result queue fills, the back stops reading,
//   and once both buffer banks hold finished chunks full rises.
//   Reset: synchronous; clears counters, the front's sum and the queues. The
//   buffer and the back's rest sum are not cleared; both are written before use.
module tryte_chunk_sum_normalizer
   import tcsn_pkg::*;
#(
   parameter int CHUNK_LEN = CHUNK_LEN_DEF,
   parameter int TRYTE_MAX = TRYTE_MAX_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   output logic                      full,
   input  logic signed [TRYTE_W-1:0] req_tryte_in,
   output logic                      empty,
   input  logic                      pop,
   output logic signed [TRYTE_W-1:0] rsp_tryte_out,
   output logic                      rsp_chunk_last
);

   localparam int SUM_W  = sum_width(CHUNK_LEN, TRYTE_MAX);
   localparam int AW     = $clog2(NUM_BANKS * CHUNK_LEN);
   localparam int CNT_W  = $clog2(FIFO_DEPTH + 1);

   logic              ram_wr_en, ram_rd_en;
   logic [AW-1:0]     ram_wr_addr, ram_rd_addr;
   logic [TRYTE_W-1:0] ram_wr_data, ram_rd_data;
   logic              desc_push, desc_pop, desc_empty, desc_full;
   logic [SUM_W:0]    desc_wr_data, desc_rd_data;
   logic [CNT_W-1:0]  desc_count;
   logic              bank_free;

   tcsn_front #(
      .CHUNK_LEN (CHUNK_LEN),
      .TRYTE_MAX (TRYTE_MAX)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .push         (push),
      .full         (full),
      .req_tryte_in (req_tryte_in),
      .ram_wr_en    (ram_wr_en),
      .ram_wr_addr  (ram_wr_addr),
      .ram_wr_data  (ram_wr_data),
      .desc_push    (desc_push),
      .desc_data    (desc_wr_data),
      .bank_free    (bank_free)
   );

   tcsn_fifo #(
      .WIDTH (SUM_W + 1)
   ) u_desc_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (desc_push),
      .push_data (desc_wr_data),
      .pop       (desc_pop),
      .pop_data  (desc_rd_data),
      .empty     (desc_empty),
      .full      (desc_full),
      .count     (desc_count)
   );

   tcsn_ram #(
      .WIDTH (TRYTE_W),
      .DEPTH (NUM_BANKS * CHUNK_LEN)
   ) u_chunk_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   tcsn_back #(
      .CHUNK_LEN (CHUNK_LEN),
      .TRYTE_MAX (TRYTE_MAX)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .desc_empty     (desc_empty),
      .desc_data      (desc_rd_data),
      .desc_pop       (desc_pop),
      .ram_rd_en      (ram_rd_en),
      .ram_rd_addr    (ram_rd_addr),
      .ram_rd_data    (ram_rd_data),
      .bank_free      (bank_free),
      .rsp_tryte_out  (rsp_tryte_out),
      .rsp_chunk_last (rsp_chunk_last),
      .empty          (empty),
      .pop            (pop)
   );

   a_desc_no_overflow: assert property (@(posedge clock) disable iff (reset)
      desc_push |-> !desc_full)
      else $error("chunk descriptor pushed into a full queue");

   a_desc_bound: assert property (@(posedge clock) disable iff (reset)
      desc_count <= CNT_W'(NUM_BANKS))
      else $error("more pending chunks than buffer banks");

   a_wr_rd_banks_apart: assert property (@(posedge clock) disable iff (reset)
      (ram_wr_en && ram_rd_en) |-> (ram_wr_addr != ram_rd_addr))
      else $error("front and back touch the same buffer entry");

endmodule

### rtl/tcsn_fifo.sv
// Small register FIFO of FIFO_DEPTH entries with push/pop handshake.
// Depends on tcsn_pkg.
module tcsn_fifo
   import tcsn_pkg::*;
#(
   parameter int WIDTH = 8
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  push,
   input  logic [WIDTH-1:0]                      push_data,
   input  logic                                  pop,
   output logic [WIDTH-1:0]                      pop_data,
   output logic                                  empty,
   output logic                                  full,
   output logic [$clog2(FIFO_DEPTH+1)-1:0]       count
);

   localparam int PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
   localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

   logic [WIDTH-1:0] entry_ff [FIFO_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign empty    = (count_ff == '0);
   assign full     = (count_ff == CNT_W'(FIFO_DEPTH));
   assign count    = count_ff;
   assign pop_data = entry_ff[rd_ptr_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

### rtl/tcsn_ram.sv
// Generic simple dual-port RAM: one write port, one read port with registered data.
// Depends on tcsn_pkg for the default WIDTH (TRYTE_W).
module tcsn_ram
   import tcsn_pkg::*;
#(
   parameter int WIDTH = TRYTE_W,
   parameter int DEPTH = 2
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   assign rd_data = rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

endmodule

### rtl/tcsn_front.sv
// Front part: accepts trytes, saturates them, writes the chunk buffer and sums the chunk.
// Depends on tcsn_pkg; feeds the chunk descriptor queue and the chunk buffer RAM.
module tcsn_front
   import tcsn_pkg::*;
#(
   parameter int CHUNK_LEN = CHUNK_LEN_DEF,
   parameter int TRYTE_MAX = TRYTE_MAX_DEF
) (
   input  logic                                              clock,
   input  logic                                              reset,
   input  logic                                              push,
   output logic                                              full,
   input  logic signed [TRYTE_W-1:0]                         req_tryte_in,
   output logic                                              ram_wr_en,
   output logic [$clog2(NUM_BANKS*CHUNK_LEN)-1:0]            ram_wr_addr,
   output logic [TRYTE_W-1:0]                                ram_wr_data,
   output logic                                              desc_push,
   output logic [sum_width(CHUNK_LEN, TRYTE_MAX):0]          desc_data,
   input  logic                                              bank_free
);

   localparam int SUM_W = sum_width(CHUNK_LEN, TRYTE_MAX);
   localparam int IDX_W = index_width(CHUNK_LEN);
   localparam int AW    = $clog2(NUM_BANKS * CHUNK_LEN);
   localparam int CNT_W = $clog2(NUM_BANKS + 1);
   localparam logic signed [TRYTE_W-1:0] MAX_T = TRYTE_W'(TRYTE_MAX);

   logic [IDX_W-1:0]        idx_ff, idx_in;
   logic                    bank_ff, bank_in;
   logic signed [SUM_W-1:0] sum_ff, sum_in;
   logic [CNT_W-1:0]        owned_ff, owned_in;
   logic                    accept, chunk_end;
   logic signed [TRYTE_W-1:0] sat;
   logic signed [SUM_W-1:0]   chunk_sum;

   // back holds every bank: stop taking trytes
   assign full      = (owned_ff == CNT_W'(NUM_BANKS));
   assign accept    = push && !full;
   assign chunk_end = accept && (idx_ff == IDX_W'(CHUNK_LEN - 1));

   always_comb begin
      if (req_tryte_in > MAX_T) begin
         sat = MAX_T;
      end else if (req_tryte_in < -MAX_T) begin
         sat = -MAX_T;
      end else begin
         sat = req_tryte_in;
      end
   end

   assign chunk_sum   = sum_ff + SUM_W'(sat);
   assign ram_wr_en   = accept;
   assign ram_wr_data = sat;
   assign ram_wr_addr = AW'(idx_ff) + (bank_ff ? AW'(CHUNK_LEN) : AW'(0));
   assign desc_push   = chunk_end;
   assign desc_data   = {bank_ff, chunk_sum};

   always_comb begin
      idx_in   = idx_ff;
      bank_in  = bank_ff;
      sum_in   = sum_ff;
      owned_in = owned_ff;
      if (accept) begin
         if (chunk_end) begin
            idx_in  = '0;
            sum_in  = '0;
            bank_in = !bank_ff;
         end else begin
            idx_in = idx_ff + 1'b1;
            sum_in = chunk_sum;
         end
      end
      if (chunk_end && !bank_free) begin
         owned_in = owned_ff + 1'b1;
      end else if (bank_free && !chunk_end) begin
         owned_in = owned_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= '0;
         bank_ff  <= 1'b0;
         sum_ff   <= '0;
         owned_ff <= '0;
      end else begin
         idx_ff   <= idx_in;
         bank_ff  <= bank_in;
         sum_ff   <= sum_in;
         owned_ff <= owned_in;
      end
   end

   a_owned_bound: assert property (@(posedge clock) disable iff (reset)
      owned_ff <= CNT_W'(NUM_BANKS))
      else $error("more chunks handed to the back than banks exist");

   a_free_needs_owner: assert property (@(posedge clock) disable iff (reset)
      bank_free |-> (owned_ff != '0))
      else $error("bank freed while the back owns none");

   a_bank_flips: assert property (@(posedge clock) disable iff (reset)
      chunk_end |=> (bank_ff != $past(bank_ff)) && (idx_ff == '0))
      else $error("chunk end did not switch banks");

endmodule

### rtl/tcsn_back.sv
// Back part: takes chunk descriptors, reads the buffered chunk, balances it and emits it.
// Depends on tcsn_pkg and tcsn_fifo (result queue).
module tcsn_back
   import tcsn_pkg::*;
#(
   parameter int CHUNK_LEN = CHUNK_LEN_DEF,
   parameter int TRYTE_MAX = TRYTE_MAX_DEF
) (
   input  logic                                              clock,
   input  logic                                              reset,
   input  logic                                              desc_empty,
   input  logic [sum_width(CHUNK_LEN, TRYTE_MAX):0]          desc_data,
   output logic                                              desc_pop,
   output logic                                              ram_rd_en,
   output logic [$clog2(NUM_BANKS*CHUNK_LEN)-1:0]            ram_rd_addr,
   input  logic [TRYTE_W-1:0]                                ram_rd_data,
   output logic                                              bank_free,
   output logic signed [TRYTE_W-1:0]                         rsp_tryte_out,
   output logic                                              rsp_chunk_last,
   output logic                                              empty,
   input  logic                                              pop
);

   localparam int SUM_W = sum_width(CHUNK_LEN, TRYTE_MAX);
   localparam int IDX_W = index_width(CHUNK_LEN);
   localparam int AW    = $clog2(NUM_BANKS * CHUNK_LEN);
   localparam int CNT_W = $clog2(FIFO_DEPTH + 1);
   localparam logic signed [SUM_W-1:0] MAX_S = SUM_W'(TRYTE_MAX);

   back_state_type state_ff, state_in;
   logic [IDX_W-1:0]        idx_ff, idx_in;
   logic                    bank_ff, bank_in;
   logic signed [SUM_W-1:0] rest_ff, rest_in;
   logic                    rd_valid_ff, rd_last_ff, rd_last_in;
   logic                    start, issue, last_issue;

   logic [CNT_W-1:0]        out_count;
   logic                    out_full, out_pop_fire;
   logic [CNT_W:0]          occupancy;
   logic [TRYTE_W:0]        out_data;

   logic signed [TRYTE_W-1:0] rd_tryte;
   logic signed [SUM_W-1:0]   t_ext, room, need, take, adj, rest_next;

   // credit: a read may be issued only when its data has a free result slot
   assign out_pop_fire = pop && !empty;
   assign occupancy    = {1'b0, out_count} + (CNT_W + 1)'(rd_valid_ff)
                         - (CNT_W + 1)'(out_pop_fire);

   always_comb begin
      state_in   = state_ff;
      idx_in     = idx_ff;
      bank_in    = bank_ff;
      start      = 1'b0;
      issue      = 1'b0;
      last_issue = 1'b0;
      rd_last_in = rd_last_ff;
      unique case (state_ff)
         BACK_IDLE: begin
            // wait for the previous chunk's last tryte before loading a new sum
            if (!desc_empty && !rd_valid_ff) begin
               start    = 1'b1;
               idx_in   = '0;
               bank_in  = desc_data[SUM_W];
               state_in = BACK_RUN;
            end
         end
         BACK_RUN: begin
            if (occupancy < (CNT_W + 1)'(FIFO_DEPTH)) begin
               issue      = 1'b1;
               last_issue = (idx_ff == IDX_W'(CHUNK_LEN - 1));
               rd_last_in = last_issue;
               if (last_issue) begin
                  state_in = BACK_IDLE;
               end else begin
                  idx_in = idx_ff + 1'b1;
               end
            end
         end
         default: begin
            state_in = BACK_IDLE;
         end
      endcase
   end

   assign desc_pop    = start;
   assign ram_rd_en   = issue;
   assign ram_rd_addr = AW'(idx_ff) + (bank_ff ? AW'(CHUNK_LEN) : AW'(0));
   assign bank_free   = last_issue;

   // absorb as much of the remaining sum as this tryte's bound allows
   assign rd_tryte = ram_rd_data;
   assign t_ext    = SUM_W'(rd_tryte);

   always_comb begin
      room      = '0;
      need      = '0;
      take      = '0;
      adj       = t_ext;
      rest_next = rest_ff;
      if (rest_ff > 0) begin
         room      = t_ext + MAX_S;
         take      = (rest_ff < room) ? rest_ff : room;
         adj       = t_ext - take;
         rest_next = rest_ff - take;
      end else if (rest_ff < 0) begin
         room      = MAX_S - t_ext;
         need      = -rest_ff;
         take      = (need < room) ? need : room;
         adj       = t_ext + take;
         rest_next = rest_ff + take;
      end
   end

   always_comb begin
      rest_in = rest_ff;
      if (start) begin
         rest_in = desc_data[SUM_W-1:0];
      end else if (rd_valid_ff) begin
         rest_in = rest_next;
      end
   end

   assign out_data = {adj[TRYTE_W-1:0], rd_last_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= BACK_IDLE;
         idx_ff      <= '0;
         bank_ff     <= 1'b0;
         rd_valid_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         idx_ff      <= idx_in;
         bank_ff     <= bank_in;
         rd_valid_ff <= issue;
      end
   end

   always_ff @(posedge clock) begin
      rest_ff    <= rest_in;
      rd_last_ff <= rd_last_in;
   end

   tcsn_fifo #(
      .WIDTH (TRYTE_W + 1)
   ) u_out_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (rd_valid_ff),
      .push_data (out_data),
      .pop       (pop),
      .pop_data  ({rsp_tryte_out, rsp_chunk_last}),
      .empty     (empty),
      .full      (out_full),
      .count     (out_count)
   );

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      rd_valid_ff |-> !out_full)
      else $error("read data returned into a full result queue");

   a_sum_cleared: assert property (@(posedge clock) disable iff (reset)
      (rd_valid_ff && rd_last_ff) |=> (rest_ff == '0))
      else $error("chunk sum not driven to zero by its last tryte");

   a_start_quiet: assert property (@(posedge clock) disable iff (reset)
      start |-> !rd_valid_ff && !issue)
      else $error("new chunk loaded while reads are in flight");

endmodule
